// ----- sv/efd_pkg.sv -----
// Package for the encoder frame deframer: operation codes, command kinds,
// frame constants and the command and result item types. No dependencies.
package efd_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int CNT_W       = 4;

    localparam logic [7:0]  HDR_BYTE0  = 8'hAA;
    localparam logic [7:0]  FILL_BYTE  = 8'hFF;
    localparam logic [15:0] COMP_MASK  = 16'hFFFF;
    localparam logic [7:0]  LIMIT_RST  = 8'd100;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_LATCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TYPE_ANGLE = 2'd1,
        TYPE_ERROR = 2'd2
    } t_frame_type;

    typedef enum logic [2:0] {
        K_START,
        K_BYTE,
        K_LAST,
        K_SKIP,
        K_TICK,
        K_LATCH
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] idx;
        logic [7:0]       data;
    } t_cmd;

    typedef struct packed {
        logic [11:0] angle;
        logic        angle_upper_half;
        logic        new_angle;
        logic [15:0] error_word;
        logic        verify_error;
        logic        format_error;
        logic        frame_done;
        logic        frame_bad;
        logic        busy_res;
        logic [15:0] timeout_events;
        logic [15:0] angle_frames;
        logic [11:0] held_angle;
    } t_result;

endpackage

// ----- sv/efd_fifo.sv -----
// Small first-in first-out queue of packed words.
// No dependencies; used between the front, the back and the result ports.
module efd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- sv/efd_front.sv -----
// Front end: accepts operation items, tracks the byte position in the frame
// and turns each item into a command. Depends on efd_pkg.
module efd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_operation,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_full,
    output logic          o_push,
    output efd_pkg::t_cmd o_cmd
);
    logic [efd_pkg::CNT_W-1:0] r_count, n_count;
    logic                      accept;

    assign accept = i_push && !i_full;
    assign o_push = i_push;

    always_comb begin
        n_count    = r_count;
        o_cmd.idx  = r_count;
        o_cmd.data = i_rx_byte;
        o_cmd.kind = efd_pkg::K_SKIP;
        case (efd_pkg::t_op'(i_operation))
            efd_pkg::OP_START: begin
                o_cmd.kind = efd_pkg::K_START;
                n_count    = '0;
            end
            efd_pkg::OP_BYTE: begin
                if (r_count < efd_pkg::CNT_W'(efd_pkg::FRAME_BYTES)) begin
                    n_count = r_count + 1'b1;
                    if (r_count == efd_pkg::CNT_W'(efd_pkg::FRAME_BYTES - 1)) begin
                        o_cmd.kind = efd_pkg::K_LAST;
                    end else begin
                        o_cmd.kind = efd_pkg::K_BYTE;
                    end
                end
            end
            efd_pkg::OP_TICK:  o_cmd.kind = efd_pkg::K_TICK;
            efd_pkg::OP_LATCH: o_cmd.kind = efd_pkg::K_LATCH;
            default:           o_cmd.kind = efd_pkg::K_SKIP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/efd_back.sv -----
// Back end: executes commands, holds the frame bytes and all status state,
// and emits one result item per command. Depends on efd_pkg.
module efd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  efd_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    input  logic             i_res_full,
    output efd_pkg::t_result o_res,
    input  logic             i_cfg_valid,
    input  logic [7:0]       i_cfg_timeout_limit
);
    logic [7:0]  r_store [efd_pkg::FRAME_BYTES-1];
    logic [7:0]  r_limit;
    logic        r_busy, n_busy;
    logic [7:0]  r_tick, n_tick;
    logic [15:0] r_timeouts, n_timeouts;
    logic [11:0] r_angle, n_angle;
    logic        r_half, n_half;
    logic        r_new, n_new;
    logic [15:0] r_error, n_error;
    logic        r_verify, n_verify;
    logic        r_format, n_format;
    logic [15:0] r_frames, n_frames;
    logic [11:0] r_held, n_held;
    logic        done;
    logic        bad;
    logic [15:0] word;
    logic [15:0] comp;

    assign o_cmd_take = i_cmd_valid && !i_res_full;
    assign word = {r_store[2], r_store[3]};
    assign comp = {r_store[4], r_store[5]};

    always_comb begin
        bad = (r_store[0] != efd_pkg::HDR_BYTE0) || (r_store[1] != efd_pkg::FILL_BYTE) ||
              (r_store[6] != efd_pkg::FILL_BYTE) || (r_store[7] != efd_pkg::FILL_BYTE) ||
              (r_store[8] != efd_pkg::FILL_BYTE) || (i_cmd.data != efd_pkg::FILL_BYTE);
    end

    always_comb begin
        n_busy     = r_busy;
        n_tick     = r_tick;
        n_timeouts = r_timeouts;
        n_angle    = r_angle;
        n_half     = r_half;
        n_new      = r_new;
        n_error    = r_error;
        n_verify   = r_verify;
        n_format   = r_format;
        n_frames   = r_frames;
        n_held     = r_held;
        done       = 1'b0;
        case (i_cmd.kind)
            efd_pkg::K_START: begin
                n_tick = '0;
                n_busy = 1'b1;
            end
            efd_pkg::K_LAST: begin
                done   = 1'b1;
                n_busy = 1'b0;
                if (!bad) begin
                    if ((word ^ comp) != efd_pkg::COMP_MASK) begin
                        n_verify = 1'b1;
                    end else begin
                        case (word[1:0])
                            efd_pkg::TYPE_ANGLE: begin
                                n_angle  = word[15:4];
                                n_half   = word[15];
                                n_new    = 1'b1;
                                n_frames = r_frames + 1'b1;
                                n_verify = 1'b0;
                                n_format = 1'b0;
                            end
                            efd_pkg::TYPE_ERROR: begin
                                n_error  = word;
                                n_verify = 1'b0;
                                n_format = 1'b0;
                            end
                            default: n_format = 1'b1;
                        endcase
                    end
                end
            end
            efd_pkg::K_TICK: begin
                if (r_busy) begin
                    if (r_tick > r_limit) begin
                        n_tick     = '0;
                        n_busy     = 1'b0;
                        n_timeouts = r_timeouts + 1'b1;
                    end else begin
                        n_tick = r_tick + 1'b1;
                    end
                end else begin
                    n_tick = '0;
                end
            end
            efd_pkg::K_LATCH: begin
                if (r_error == '0 && !r_verify && !r_format) begin
                    n_held = r_angle;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.angle            = n_angle;
        o_res.angle_upper_half = n_half;
        o_res.new_angle        = n_new;
        o_res.error_word       = n_error;
        o_res.verify_error     = n_verify;
        o_res.format_error     = n_format;
        o_res.frame_done       = done;
        o_res.frame_bad        = done && bad;
        o_res.busy_res         = n_busy;
        o_res.timeout_events   = n_timeouts;
        o_res.angle_frames     = n_frames;
        o_res.held_angle       = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= efd_pkg::LIMIT_RST;
            r_busy     <= 1'b0;
            r_tick     <= '0;
            r_timeouts <= '0;
            r_angle    <= '0;
            r_half     <= 1'b0;
            r_new      <= 1'b0;
            r_error    <= '0;
            r_verify   <= 1'b0;
            r_format   <= 1'b0;
            r_frames   <= '0;
            r_held     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_timeout_limit;
            end
            if (o_cmd_take) begin
                r_busy     <= n_busy;
                r_tick     <= n_tick;
                r_timeouts <= n_timeouts;
                r_angle    <= n_angle;
                r_half     <= n_half;
                r_new      <= n_new;
                r_error    <= n_error;
                r_verify   <= n_verify;
                r_format   <= n_format;
                r_frames   <= n_frames;
                r_held     <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && i_cmd.kind == efd_pkg::K_BYTE) begin
            r_store[i_cmd.idx] <= i_cmd.data;
        end
    end

endmodule

// ----- sv/encoder_frame_deframer.sv -----
// Top level of the encoder frame deframer: front end, command queue, back end
// and result queue. Depends on efd_pkg, efd_front, efd_fifo and efd_back.
//
//   channel   handshake               payload
//   input     push / full             i_operation, i_rx_byte
//   result    empty / pop             o_angle ... o_held_angle (12 fields)
//   config    i_cfg_valid / o_cfg_ready   i_cfg_timeout_limit
//
// One item per cycle sustained while the queues are not full; an item's result
// reaches the result ports through the command queue, then the result queue.
// Reset is synchronous; it empties both queues and clears all status state.
// A stalled result side fills the result queue, then the command queue, then
// raises full; the config channel is always ready.
module encoder_frame_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] o_angle,
    output logic        o_angle_upper_half,
    output logic        o_new_angle,
    output logic [15:0] o_error_word,
    output logic        o_verify_error,
    output logic        o_format_error,
    output logic        o_frame_done,
    output logic        o_frame_bad,
    output logic        o_busy_res,
    output logic [15:0] o_timeout_events,
    output logic [15:0] o_angle_frames,
    output logic [11:0] o_held_angle,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_timeout_limit
);
    localparam int CMD_W = $bits(efd_pkg::t_cmd);
    localparam int RES_W = $bits(efd_pkg::t_result);

    efd_pkg::t_cmd    front_cmd;
    efd_pkg::t_cmd    back_cmd;
    efd_pkg::t_result back_res;
    efd_pkg::t_result out_res;
    logic             front_push;
    logic             cmd_empty;
    logic             cmd_take;
    logic             res_full;

    assign o_cfg_ready = 1'b1;

    efd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_operation(i_operation),
        .i_rx_byte  (i_rx_byte),
        .i_full     (full),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    efd_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_data (front_cmd),
        .o_full (full),
        .i_pop  (cmd_take),
        .o_data (back_cmd),
        .o_empty(cmd_empty)
    );

    efd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_valid        (!cmd_empty),
        .i_cmd              (back_cmd),
        .o_cmd_take         (cmd_take),
        .i_res_full         (res_full),
        .o_res              (back_res),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_timeout_limit(i_cfg_timeout_limit)
    );

    efd_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_take),
        .i_data (back_res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty)
    );

    assign o_angle            = out_res.angle;
    assign o_angle_upper_half = out_res.angle_upper_half;
    assign o_new_angle        = out_res.new_angle;
    assign o_error_word       = out_res.error_word;
    assign o_verify_error     = out_res.verify_error;
    assign o_format_error     = out_res.format_error;
    assign o_frame_done       = out_res.frame_done;
    assign o_frame_bad        = out_res.frame_bad;
    assign o_busy_res         = out_res.busy_res;
    assign o_timeout_events   = out_res.timeout_events;
    assign o_angle_frames     = out_res.angle_frames;
    assign o_held_angle       = out_res.held_angle;

endmodule

// ----- sv/efd_checker.sv -----
// Port-level checks for the encoder frame deframer, bound to its top level.
// Depends only on the top-level ports.
module efd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_new_angle,
    input logic        o_frame_done,
    input logic        o_frame_bad,
    input logic        o_busy_res,
    input logic [15:0] o_angle_frames
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_bad_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_bad |-> o_frame_done)
        else $error("bad frame flagged without a completed frame");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_done |-> !o_busy_res)
        else $error("busy after a completed frame");

    a_no_angle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_new_angle |-> o_angle_frames == 16'd0)
        else $error("angle frames counted without new angle flag");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_angle_frames))
        else $error("stalled result item changed");

endmodule

bind encoder_frame_deframer efd_checker u_efd_checker (.*);
